/* hw/rtl/tmp_pkg.sv */
// Shared types and constants for the trapezoid move planner.
// Used by every module of the block; depends on nothing else.
package tmp_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_ACCEL0 = 3'd0;
    localparam logic [2:0] CFG_ACCEL1 = 3'd1;
    localparam logic [2:0] CFG_ACCEL2 = 3'd2;
    localparam logic [2:0] CFG_SPEED0 = 3'd3;
    localparam logic [2:0] CFG_SPEED1 = 3'd4;
    localparam logic [2:0] CFG_SPEED2 = 3'd5;

    // result status codes
    localparam logic [1:0] ST_PROFILE  = 2'd0;
    localparam logic [1:0] ST_NOMOVE   = 2'd1;
    localparam logic [1:0] ST_ZEROTIME = 2'd2;
    localparam logic [1:0] ST_PLAN     = 2'd3;

    // drive roles
    localparam logic [1:0] ROLE_AXIS     = 2'd0;
    localparam logic [1:0] ROLE_EXTRUDER = 2'd1;

    // arithmetic unit operations
    localparam logic [1:0] OP_MUL  = 2'd0;
    localparam logic [1:0] OP_DIV  = 2'd1;
    localparam logic [1:0] OP_SQRT = 2'd2;

    localparam logic [26:0] ACCEL_RST = 27'd1000000;
    localparam logic [23:0] SPEED_RST = 24'd300000;

    typedef struct packed {
        logic [2:0][26:0] accel;
        logic [2:0][23:0] speed;
    } t_cfg;

    // classified drive word passed from front to back
    typedef struct packed {
        logic [2:0]  drive;
        logic        axis;
        logic        ext;
        logic [1:0]  rsel;
        logic [30:0] mag;
        logic [31:0] steps;
        logic        keep;
        logic [23:0] feed;
        logic        last;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] accel_clocks;
        logic [31:0] steady_clocks;
        logic [31:0] decel_clocks;
        logic [23:0] top_speed;
        logic [30:0] accel_used;
        logic [30:0] accel_distance;
        logic [30:0] path_length;
        logic [2:0]  plan_drive;
        logic [31:0] plan_steps;
        logic [23:0] plan_rate;
        logic        last_result;
    } t_result;

    typedef struct packed {
        logic        start;
        logic [1:0]  op;
        logic [95:0] a;
        logic [63:0] b;
    } t_ar_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [95:0] res;
    } t_ar_rsp;

endpackage

/* hw/rtl/tmp_front.sv */
// Front end: accepts drive words, classifies them and counts stored entries.
// Depends on tmp_pkg.
module tmp_front import tmp_pkg::*; #(
    parameter int MAX_DRIVES  = 8,
    parameter int MOTION_AXES = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_drive_number,
    input  logic [1:0]         i_drive_role,
    input  logic               i_axis_counts,
    input  logic signed [30:0] i_coord_delta,
    input  logic signed [31:0] i_step_delta,
    input  logic [23:0]        i_feed_rate,
    input  logic               i_last_drive,
    output logic               o_push,
    input  logic               i_q_ready,
    output t_item              o_item
);
    localparam int CW = $clog2(MAX_DRIVES + 1);

    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          keep;

    assign o_in_ready = i_q_ready;
    assign o_push     = i_in_valid;
    assign keep       = (r_cnt < CW'(MAX_DRIVES));

    // classify the word
    always_comb begin
        o_item.drive = i_drive_number;
        o_item.axis  = (i_drive_role == ROLE_AXIS) && i_axis_counts
                       && (32'(i_drive_number) < MOTION_AXES);
        o_item.ext   = (i_drive_role == ROLE_EXTRUDER);
        o_item.rsel  = (i_drive_number > 3'd2) ? 2'd2 : i_drive_number[1:0];
        o_item.mag   = i_coord_delta[30]
                       ? 31'(32'h8000_0000 - {1'b0, i_coord_delta})
                       : i_coord_delta;
        o_item.steps = i_step_delta;
        o_item.keep  = keep;
        o_item.feed  = i_feed_rate;
        o_item.last  = i_last_drive;
    end

    // stored entry count of the open move
    always_comb begin
        n_cnt = r_cnt;
        if (i_in_valid && i_q_ready) begin
            if (i_last_drive) begin
                n_cnt = '0;
            end else if (keep) begin
                n_cnt = r_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end
endmodule

/* hw/rtl/tmp_fifo.sv */
// Two-word queue between front end and back end.
// Depends on tmp_pkg for the word type.
module tmp_fifo import tmp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_data
);
    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

/* hw/rtl/tmp_arith.sv */
// Shared bit-serial arithmetic unit: multiply, divide, rounded square root.
// Depends on tmp_pkg.
module tmp_arith import tmp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_ar_req i_req,
    output t_ar_rsp o_rsp
);
    logic        r_busy;
    logic        r_done;
    logic [1:0]  r_op;
    logic [6:0]  r_cnt;
    logic [95:0] r_acc;
    logic [95:0] r_x;
    logic [63:0] r_b;
    logic [64:0] r_rem;

    logic [64:0] div_sh;
    logic [64:0] sq_sh;
    logic [64:0] sq_trial;
    logic        rnd_up;

    assign div_sh   = {r_rem[63:0], r_x[95]};
    assign sq_sh    = {r_rem[62:0], r_x[95:94]};
    assign sq_trial = {r_acc[62:0], 2'b01};
    assign rnd_up   = (r_op == OP_SQRT) && ({31'd0, r_rem} > r_acc);

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.res  = rnd_up ? r_acc + 96'd1 : r_acc;

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_op  <= i_req.op;
            r_rem <= '0;
            r_acc <= '0;
            case (i_req.op)
                OP_MUL: begin
                    r_x   <= {32'd0, i_req.a[63:0]};
                    r_b   <= {32'd0, i_req.b[31:0]};
                    r_cnt <= 7'd32;
                end
                OP_DIV: begin
                    r_x   <= i_req.a;
                    r_b   <= i_req.b;
                    r_cnt <= 7'd96;
                end
                default: begin
                    r_x   <= i_req.a;
                    r_b   <= i_req.b;
                    r_cnt <= 7'd48;
                end
            endcase
        end else if (r_busy) begin
            r_cnt <= r_cnt - 7'd1;
            case (r_op)
                OP_MUL: begin
                    if (r_b[0]) begin
                        r_acc <= r_acc + r_x;
                    end
                    r_x <= {r_x[94:0], 1'b0};
                    r_b <= {1'b0, r_b[63:1]};
                end
                OP_DIV: begin
                    r_x <= {r_x[94:0], 1'b0};
                    if (div_sh >= {1'b0, r_b}) begin
                        r_rem <= div_sh - {1'b0, r_b};
                        r_acc <= {r_acc[94:0], 1'b1};
                    end else begin
                        r_rem <= div_sh;
                        r_acc <= {r_acc[94:0], 1'b0};
                    end
                end
                default: begin
                    r_x <= {r_x[93:0], 2'b00};
                    if (sq_sh >= sq_trial) begin
                        r_rem <= sq_sh - sq_trial;
                        r_acc <= {r_acc[94:0], 1'b1};
                    end else begin
                        r_rem <= sq_sh;
                        r_acc <= {r_acc[94:0], 1'b0};
                    end
                end
            endcase
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 7'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end
endmodule

/* hw/rtl/tmp_back.sv */
// Back end: stores the move's entries, sequences the profile math on the
// shared arithmetic unit and drives the result register. Depends on tmp_pkg.
module tmp_back import tmp_pkg::*; #(
    parameter int MAX_DRIVES = 8,
    parameter int TICK_RATE  = 1000000
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_q_valid,
    output logic    o_q_ready,
    input  t_item   i_item,
    output t_ar_req o_ar,
    input  t_ar_rsp i_ar,
    output t_result o_res,
    output logic    o_out_valid,
    input  logic    i_out_ready
);
    localparam int CW = $clog2(MAX_DRIVES + 1);
    localparam int IW = (MAX_DRIVES > 1) ? $clog2(MAX_DRIVES) : 1;
    localparam longint unsigned TSQ = longint'(TICK_RATE) * longint'(TICK_RATE);

    localparam logic [4:0] S_LOAD = 5'd0;
    localparam logic [4:0] S_SQ   = 5'd1;
    localparam logic [4:0] S_WSQ  = 5'd2;
    localparam logic [4:0] S_WL   = 5'd3;
    localparam logic [4:0] S_CAP  = 5'd4;
    localparam logic [4:0] S_CA1  = 5'd5;
    localparam logic [4:0] S_CA2  = 5'd6;
    localparam logic [4:0] S_CS1  = 5'd7;
    localparam logic [4:0] S_CS2  = 5'd8;
    localparam logic [4:0] S_AV   = 5'd9;
    localparam logic [4:0] S_LA0  = 5'd10;
    localparam logic [4:0] S_LA   = 5'd11;
    localparam logic [4:0] S_VV   = 5'd12;
    localparam logic [4:0] S_T1   = 5'd13;
    localparam logic [4:0] S_T2   = 5'd14;
    localparam logic [4:0] S_T3   = 5'd15;
    localparam logic [4:0] S_T4   = 5'd16;
    localparam logic [4:0] S_P1   = 5'd17;
    localparam logic [4:0] S_P2   = 5'd18;
    localparam logic [4:0] S_P3   = 5'd19;
    localparam logic [4:0] S_P4   = 5'd20;
    localparam logic [4:0] S_P5   = 5'd21;
    localparam logic [4:0] S_P6   = 5'd22;
    localparam logic [4:0] S_TOT  = 5'd23;
    localparam logic [4:0] S_SCAN = 5'd24;
    localparam logic [4:0] S_R1   = 5'd25;
    localparam logic [4:0] S_R2   = 5'd26;
    localparam logic [4:0] S_EMIT = 5'd27;

    // entry store
    logic [2:0]  r_drv   [MAX_DRIVES];
    logic        r_axis  [MAX_DRIVES];
    logic        r_ext   [MAX_DRIVES];
    logic [1:0]  r_rsel  [MAX_DRIVES];
    logic [30:0] r_mag   [MAX_DRIVES];
    logic [31:0] r_steps [MAX_DRIVES];

    logic [4:0]    r_state;
    logic [4:0]    r_ret;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_left;
    logic [2:0]    r_d;
    logic [23:0]   r_req;
    logic [63:0]   r_sum;
    logic [30:0]   r_extm;
    logic          r_extf;
    logic          r_axf;
    logic [30:0]   r_l;
    logic [63:0]   r_amin;
    logic [63:0]   r_smin;
    logic [30:0]   r_a;
    logic [23:0]   r_v;
    logic [61:0]   r_la;
    logic [47:0]   r_vv;
    logic [55:0]   r_den;
    logic [31:0]   r_ca;
    logic [31:0]   r_cs;
    logic [23:0]   r_top;
    logic [30:0]   r_dist;
    logic [33:0]   r_total;
    logic [2:0]    r_pd;
    logic [31:0]   r_ps;
    t_result       r_stage;
    t_result       r_res;
    logic          r_ov;
    t_ar_req       r_ar;

    logic [IW-1:0] ix;
    logic [30:0]   n_l;
    logic [30:0]   n_a;
    logic [23:0]   n_v;
    logic [63:0]   a_raw;
    logic [23:0]   req_eff;
    logic [33:0]   n_total;
    logic [CW-1:0] n_left;
    logic [32:0]   cur_abs;
    logic [31:0]   sat32;
    logic [23:0]   sat24;
    logic          adv_wrap;

    assign ix          = r_idx[IW-1:0];
    assign o_q_ready   = (r_state == S_LOAD);
    assign o_ar        = r_ar;
    assign o_res       = r_res;
    assign o_out_valid = r_ov;

    // saturations of the arithmetic result
    assign sat32 = (i_ar.res[95:32] != '0) ? 32'hFFFF_FFFF : i_ar.res[31:0];
    assign sat24 = (i_ar.res[95:24] != '0) ? 24'hFF_FFFF : i_ar.res[23:0];

    // path length with extruder fallback
    always_comb begin
        n_l = (i_ar.res > 96'h7FFF_FFFF) ? 31'h7FFF_FFFF : i_ar.res[30:0];
        if (n_l == '0) begin
            n_l = r_extm;
        end
    end

    // effective acceleration and speed
    always_comb begin
        a_raw = r_axf ? r_amin : {37'd0, i_cfg.accel[0]};
        if (a_raw == '0) begin
            n_a = 31'd1;
        end else if (a_raw > 64'h7FFF_FFFF) begin
            n_a = 31'h7FFF_FFFF;
        end else begin
            n_a = a_raw[30:0];
        end
        req_eff = (r_req != '0) ? r_req : i_cfg.speed[0];
        n_v = (r_axf && r_smin < {40'd0, req_eff}) ? r_smin[23:0] : req_eff;
        if (n_v == '0) begin
            n_v = 24'd1;
        end
    end

    // total clocks and number of drive plans
    always_comb begin
        n_total = {2'b00, r_ca} + {2'b00, r_cs} + {2'b00, r_ca};
        n_left  = '0;
        for (int i = 0; i < MAX_DRIVES; i++) begin
            n_left = n_left + CW'((CW'(i) < r_n) && (r_steps[i] != '0));
        end
    end

    assign cur_abs  = r_steps[ix][31] ? 33'h1_0000_0000 - {1'b0, r_steps[ix]}
                                      : {1'b0, r_steps[ix]};
    assign adv_wrap = (r_idx + CW'(1) == r_n);

    // entry store writes
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD && i_q_valid && i_item.keep) begin
            r_drv[r_n[IW-1:0]]   <= i_item.drive;
            r_axis[r_n[IW-1:0]]  <= i_item.axis;
            r_ext[r_n[IW-1:0]]   <= i_item.ext;
            r_rsel[r_n[IW-1:0]]  <= i_item.rsel;
            r_mag[r_n[IW-1:0]]   <= i_item.mag;
            r_steps[r_n[IW-1:0]] <= i_item.steps;
        end
    end

    // move sequencer
    always_ff @(posedge i_clk) begin
        r_ar.start <= 1'b0;
        if (r_ov && i_out_ready) begin
            r_ov <= 1'b0;
        end
        case (r_state)
            S_LOAD: begin
                if (i_q_valid) begin
                    r_req <= i_item.feed;
                    if (i_item.keep) begin
                        r_n <= r_n + CW'(1);
                    end
                    if (i_item.last) begin
                        r_sum   <= '0;
                        r_extf  <= 1'b0;
                        r_extm  <= '0;
                        r_idx   <= '0;
                        r_state <= S_SQ;
                    end
                end
            end
            // sum of squared axis deltas, then its square root; first extruder delta kept
            S_SQ: begin
                if (r_idx == r_n) begin
                    r_ar.start <= 1'b1;
                    r_ar.op    <= OP_SQRT;
                    r_ar.a     <= {32'd0, r_sum};
                    r_ar.b     <= '0;
                    r_state    <= S_WL;
                end else if (r_axis[ix]) begin
                    r_ar.start <= 1'b1;
                    r_ar.op    <= OP_MUL;
                    r_ar.a     <= {65'd0, r_mag[ix]};
                    r_ar.b     <= {33'd0, r_mag[ix]};
                    r_state    <= S_WSQ;
                end else begin
                    if (r_ext[ix] && !r_extf) begin
                        r_extf <= 1'b1;
                        r_extm <= r_mag[ix];
                    end
                    r_idx <= r_idx + CW'(1);
                end
            end
            S_WSQ: begin
                if (i_ar.done) begin
                    r_sum   <= r_sum + i_ar.res[63:0];
                    r_idx   <= r_idx + CW'(1);
                    r_state <= S_SQ;
                end
            end
            S_WL: begin
                if (i_ar.done) begin
                    r_l <= n_l;
                    if (n_l == '0) begin
                        r_stage             <= '0;
                        r_stage.status      <= ST_NOMOVE;
                        r_stage.last_result <= 1'b1;
                        r_ret               <= S_LOAD;
                        r_state             <= S_EMIT;
                    end else begin
                        r_idx   <= '0;
                        r_axf   <= 1'b0;
                        r_state <= S_CAP;
                    end
                end
            end
            // per-axis caps by direction cosine
            S_CAP: begin
                if (r_idx == r_n) begin
                    r_state <= S_AV;
                end else if (r_axis[ix] && r_mag[ix] != '0) begin
                    r_ar.start <= 1'b1;
                    r_ar.op    <= OP_MUL;
                    r_ar.a     <= {69'd0, i_cfg.accel[r_rsel[ix]]};
                    r_ar.b     <= {33'd0, r_l};
                    r_state    <= S_CA1;
                end else begin
                    r_idx <= r_idx + CW'(1);
                end
            end
            S_CA1: begin
                if (i_ar.done) begin
                    r_ar.start <= 1'b1;
                    r_ar.op    <= OP_DIV;
                    r_ar.a     <= i_ar.res;
                    r_ar.b     <= {33'd0, r_mag[ix]};
                    r_state    <= S_CA2;
                end
            end
            S_CA2: begin
                if (i_ar.done) begin
                    if (!r_axf || i_ar.res[63:0] < r_amin) begin
                        r_amin <= i_ar.res[63:0];
                    end
                    r_ar.start <= 1'b1;
                    r_ar.op    <= OP_MUL;
                    r_ar.a     <= {72'd0, i_cfg.speed[r_rsel[ix]]};
                    r_ar.b     <= {33'd0, r_l};
                    r_state    <= S_CS1;
                end
            end
            S_CS1: begin
                if (i_ar.done) begin
                    r_ar.start <= 1'b1;
                    r_ar.op    <= OP_DIV;
                    r_ar.a     <= i_ar.res;
                    r_ar.b     <= {33'd0, r_mag[ix]};
                    r_state    <= S_CS2;
                end
            end
            S_CS2: begin
                if (i_ar.done) begin
                    if (!r_axf || i_ar.res[63:0] < r_smin) begin
                        r_smin <= i_ar.res[63:0];
                    end
                    r_axf   <= 1'b1;
                    r_idx   <= r_idx + CW'(1);
                    r_state <= S_CAP;
                end
            end
            S_AV: begin
                r_a     <= n_a;
                r_v     <= n_v;
                r_state <= S_LA0;
            end
            S_LA0: begin
                r_ar.start <= 1'b1;
                r_ar.op    <= OP_MUL;
                r_ar.a     <= {65'd0, r_l};
                r_ar.b     <= {33'd0, r_a};
                r_state    <= S_LA;
            end
            S_LA: begin
                if (i_ar.done) begin
                    r_la       <= i_ar.res[61:0];
                    r_ar.start <= 1'b1;
                    r_ar.op    <= OP_MUL;
                    r_ar.a     <= {72'd0, r_v};
                    r_ar.b     <= {40'd0, r_v};
                    r_state    <= S_VV;
                end
            end
            // triangle or trapezoid
            S_VV: begin
                if (i_ar.done) begin
                    r_vv       <= i_ar.res[47:0];
                    r_ar.start <= 1'b1;
                    r_ar.op    <= OP_MUL;
                    if ({14'd0, i_ar.res[47:0]} >= r_la) begin
                        r_ar.a  <= {32'd0, 64'(TSQ)};
                        r_ar.b  <= {33'd0, r_l};
                        r_state <= S_T1;
                    end else begin
                        r_ar.a  <= {65'd0, r_a};
                        r_ar.b  <= {40'd0, r_v};
                        r_state <= S_P1;
                    end
                end
            end
            S_T1: begin
                if (i_ar.done) begin
                    r_ar.start <= 1'b1;
                    r_ar.op    <= OP_DIV;
                    r_ar.a     <= i_ar.res;
                    r_ar.b     <= {33'd0, r_a};
                    r_state    <= S_T2;
                end
            end
            S_T2: begin
                if (i_ar.done) begin
                    r_ar.start <= 1'b1;
                    r_ar.op    <= OP_SQRT;
                    r_ar.a     <= i_ar.res;
                    r_state    <= S_T3;
                end
            end
            S_T3: begin
                if (i_ar.done) begin
                    r_ca       <= sat32;
                    r_cs       <= '0;
                    r_ar.start <= 1'b1;
                    r_ar.op    <= OP_SQRT;
                    r_ar.a     <= {34'd0, r_la};
                    r_state    <= S_T4;
                end
            end
            S_T4: begin
                if (i_ar.done) begin
                    r_top   <= sat24;
                    r_dist  <= 31'(({1'b0, r_l} + 32'd1) >> 1);
                    r_state <= S_TOT;
                end
            end
            S_P1: begin
                if (i_ar.done) begin
                    r_den      <= i_ar.res[55:0];
                    r_ar.start <= 1'b1;
                    r_ar.op    <= OP_MUL;
                    r_ar.a     <= {72'd0, r_v};
                    r_ar.b     <= 64'(TICK_RATE);
                    r_state    <= S_P2;
                end
            end
            S_P2: begin
                if (i_ar.done) begin
                    r_ar.start <= 1'b1;
                    r_ar.op    <= OP_DIV;
                    r_ar.a     <= {i_ar.res[94:0], 1'b0} + {65'd0, r_a};
                    r_ar.b     <= {32'd0, r_a, 1'b0};
                    r_state    <= S_P3;
                end
            end
            S_P3: begin
                if (i_ar.done) begin
                    r_ca       <= sat32;
                    r_ar.start <= 1'b1;
                    r_ar.op    <= OP_MUL;
                    r_ar.a     <= {34'd0, r_la - {14'd0, r_vv}};
                    r_ar.b     <= 64'(TICK_RATE);
                    r_state    <= S_P4;
                end
            end
            S_P4: begin
                if (i_ar.done) begin
                    r_ar.start <= 1'b1;
                    r_ar.op    <= OP_DIV;
                    r_ar.a     <= {i_ar.res[94:0], 1'b0} + {40'd0, r_den};
                    r_ar.b     <= {7'd0, r_den, 1'b0};
                    r_state    <= S_P5;
                end
            end
            S_P5: begin
                if (i_ar.done) begin
                    r_cs       <= sat32;
                    r_ar.start <= 1'b1;
                    r_ar.op    <= OP_DIV;
                    r_ar.a     <= {48'd0, r_vv} + {65'd0, r_a};
                    r_ar.b     <= {32'd0, r_a, 1'b0};
                    r_state    <= S_P6;
                end
            end
            S_P6: begin
                if (i_ar.done) begin
                    r_dist  <= i_ar.res[30:0];
                    r_top   <= r_v;
                    r_state <= S_TOT;
                end
            end
            // profile word
            S_TOT: begin
                r_stage <= '0;
                r_state <= S_EMIT;
                if (n_total == '0) begin
                    r_stage.status      <= ST_ZEROTIME;
                    r_stage.last_result <= 1'b1;
                    r_ret               <= S_LOAD;
                end else begin
                    r_stage.status         <= ST_PROFILE;
                    r_stage.accel_clocks   <= r_ca;
                    r_stage.steady_clocks  <= r_cs;
                    r_stage.decel_clocks   <= r_ca;
                    r_stage.top_speed      <= r_top;
                    r_stage.accel_used     <= r_a;
                    r_stage.accel_distance <= r_dist;
                    r_stage.path_length    <= r_l;
                    r_stage.last_result    <= (n_left == '0);
                    r_left                 <= n_left;
                    r_total                <= n_total;
                    r_d                    <= '0;
                    r_idx                  <= '0;
                    r_ret                  <= (n_left == '0) ? S_LOAD : S_SCAN;
                end
            end
            // drive plans in drive order, then arrival order
            S_SCAN: begin
                if (adv_wrap) begin
                    r_idx <= '0;
                    r_d   <= r_d + 3'd1;
                end else begin
                    r_idx <= r_idx + CW'(1);
                end
                if (r_drv[ix] == r_d && r_steps[ix] != '0) begin
                    r_pd       <= r_drv[ix];
                    r_ps       <= r_steps[ix];
                    r_ar.start <= 1'b1;
                    r_ar.op    <= OP_MUL;
                    r_ar.a     <= {63'd0, cur_abs};
                    r_ar.b     <= 64'(TICK_RATE);
                    r_state    <= S_R1;
                end
            end
            S_R1: begin
                if (i_ar.done) begin
                    r_ar.start <= 1'b1;
                    r_ar.op    <= OP_DIV;
                    r_ar.a     <= {i_ar.res[94:0], 1'b0} + {62'd0, r_total};
                    r_ar.b     <= {29'd0, r_total, 1'b0};
                    r_state    <= S_R2;
                end
            end
            S_R2: begin
                if (i_ar.done) begin
                    r_stage             <= '0;
                    r_stage.status      <= ST_PLAN;
                    r_stage.plan_drive  <= r_pd;
                    r_stage.plan_steps  <= r_ps;
                    r_stage.plan_rate   <= sat24;
                    r_stage.last_result <= (r_left == CW'(1));
                    r_left              <= r_left - CW'(1);
                    r_ret               <= (r_left == CW'(1)) ? S_LOAD : S_SCAN;
                    r_state             <= S_EMIT;
                end
            end
            // hand the word to the output register
            S_EMIT: begin
                if (!r_ov || i_out_ready) begin
                    r_res   <= r_stage;
                    r_ov    <= 1'b1;
                    r_state <= r_ret;
                    if (r_stage.last_result) begin
                        r_n <= '0;
                    end
                end
            end
            default: begin
                r_state <= S_LOAD;
            end
        endcase
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_ov       <= 1'b0;
            r_n        <= '0;
            r_ar.start <= 1'b0;
        end
    end
endmodule

/* hw/rtl/trapezoid_move_planner_core.sv */
// Trapezoid move planner: one drive word per cycle into a two-word queue
// while the queue has room; after the last word the profile word follows,
// then each drive plan after a scan of the store. The profile math runs on
// the shared bit-serial arithmetic unit. Reset is synchronous, active low:
// clears the queue, the open move and the output register, loads the limits.
module trapezoid_move_planner_core import tmp_pkg::*; #(
    parameter int MAX_DRIVES  = 8,
    parameter int MOTION_AXES = 3,
    parameter int TICK_RATE   = 1000000
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [26:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_drive_number,
    input  logic [1:0]         i_drive_role,
    input  logic               i_axis_counts,
    input  logic signed [30:0] i_coord_delta,
    input  logic signed [31:0] i_step_delta,
    input  logic [23:0]        i_feed_rate,
    input  logic               i_last_drive,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic [31:0]        o_accel_clocks,
    output logic [31:0]        o_steady_clocks,
    output logic [31:0]        o_decel_clocks,
    output logic [23:0]        o_top_speed,
    output logic [30:0]        o_accel_used,
    output logic [30:0]        o_accel_distance,
    output logic [30:0]        o_path_length,
    output logic [2:0]         o_plan_drive,
    output logic signed [31:0] o_plan_steps,
    output logic [23:0]        o_plan_rate,
    output logic               o_last_result
);
    t_cfg    r_cfg;
    t_item   f_item;
    t_item   q_item;
    logic    f_push;
    logic    q_ready;
    logic    q_valid;
    logic    b_ready;
    t_ar_req ar_req;
    t_ar_rsp ar_rsp;
    t_result res;

    // limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel <= {ACCEL_RST, ACCEL_RST, ACCEL_RST};
            r_cfg.speed <= {SPEED_RST, SPEED_RST, SPEED_RST};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ACCEL0: r_cfg.accel[0] <= i_cfg_data;
                CFG_ACCEL1: r_cfg.accel[1] <= i_cfg_data;
                CFG_ACCEL2: r_cfg.accel[2] <= i_cfg_data;
                CFG_SPEED0: r_cfg.speed[0] <= i_cfg_data[23:0];
                CFG_SPEED1: r_cfg.speed[1] <= i_cfg_data[23:0];
                CFG_SPEED2: r_cfg.speed[2] <= i_cfg_data[23:0];
                default: begin
                end
            endcase
        end
    end

    tmp_front #(
        .MAX_DRIVES  (MAX_DRIVES),
        .MOTION_AXES (MOTION_AXES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_drive_number (i_drive_number),
        .i_drive_role   (i_drive_role),
        .i_axis_counts  (i_axis_counts),
        .i_coord_delta  (i_coord_delta),
        .i_step_delta   (i_step_delta),
        .i_feed_rate    (i_feed_rate),
        .i_last_drive   (i_last_drive),
        .o_push         (f_push),
        .i_q_ready      (q_ready),
        .o_item         (f_item)
    );

    tmp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_push),
        .o_ready (q_ready),
        .i_data  (f_item),
        .o_valid (q_valid),
        .i_ready (b_ready),
        .o_data  (q_item)
    );

    tmp_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ar_req),
        .o_rsp   (ar_rsp)
    );

    tmp_back #(
        .MAX_DRIVES (MAX_DRIVES),
        .TICK_RATE  (TICK_RATE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .o_q_ready   (b_ready),
        .i_item      (q_item),
        .o_ar        (ar_req),
        .i_ar        (ar_rsp),
        .o_res       (res),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

    // result fields
    assign o_status         = res.status;
    assign o_accel_clocks   = res.accel_clocks;
    assign o_steady_clocks  = res.steady_clocks;
    assign o_decel_clocks   = res.decel_clocks;
    assign o_top_speed      = res.top_speed;
    assign o_accel_used     = res.accel_used;
    assign o_accel_distance = res.accel_distance;
    assign o_path_length    = res.path_length;
    assign o_plan_drive     = res.plan_drive;
    assign o_plan_steps     = res.plan_steps;
    assign o_plan_rate      = res.plan_rate;
    assign o_last_result    = res.last_result;
endmodule
